>>> hdl/keyed_watchdog_timer_macros.svh
// Assertion macros for the keyed watchdog timer.
`ifndef KEYED_WATCHDOG_TIMER_MACROS_SVH
`define KEYED_WATCHDOG_TIMER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define KWDT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kwdt check failed");
// Next-cycle implication, disabled during reset.
`define KWDT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kwdt check failed");
`else
`define KWDT_ASSERT_NOW(lbl, ante, cons)
`define KWDT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hdl/kwdt_pkg.sv
// Types and constants shared by the keyed watchdog timer files.
`timescale 1ns / 1ps
package kwdt_pkg;

	localparam int PRESCALE_WIDTH = 24;
	localparam int TPHS_W         = 24;
	localparam int LIM_W          = ((PRESCALE_WIDTH > TPHS_W) ? PRESCALE_WIDTH : TPHS_W) + 1;
	localparam int HSC_W          = 6;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 24;
	localparam int DATA_W         = 32;
	localparam int OFF_W          = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TPHS   = 2'd2;

	localparam logic [TPHS_W-1:0] TPHS_RESET = 24'd16384;

	localparam logic [OFF_W-1:0] OFF_CTRL0 = 5'h00;
	localparam logic [OFF_W-1:0] OFF_MODE0 = 5'h04;
	localparam logic [OFF_W-1:0] OFF_CTRL1 = 5'h10;
	localparam logic [OFF_W-1:0] OFF_CFG1  = 5'h14;
	localparam logic [OFF_W-1:0] OFF_MODE1 = 5'h18;

	localparam logic [12:0] RELOAD_PATTERN = 13'h14AF;
	localparam logic [15:0] KEY_HALF       = 16'h16AA;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_TICK  = 2'd2
	} kwdt_mode_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [OFF_W-1:0]  reg_offset;
		logic [DATA_W-1:0] write_data;
	} kwdt_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              system_reset;
		logic              expired;
	} kwdt_result_t;

	typedef struct packed {
		logic              layout;
		logic              key_check;
		logic [TPHS_W-1:0] tphs;
	} kwdt_cfg_t;

	// Interval code to length in half seconds; codes from eleven up saturate.
	function automatic logic [HSC_W-1:0] half_seconds_of(input logic [3:0] code);
		logic [HSC_W-1:0] hs;
		case (code)
			4'd0:    hs = 6'd1;
			4'd1:    hs = 6'd2;
			4'd2:    hs = 6'd4;
			4'd3:    hs = 6'd6;
			4'd4:    hs = 6'd8;
			4'd5:    hs = 6'd10;
			4'd6:    hs = 6'd12;
			4'd7:    hs = 6'd16;
			4'd8:    hs = 6'd20;
			4'd9:    hs = 6'd24;
			4'd10:   hs = 6'd28;
			default: hs = 6'd32;
		endcase
		return hs;
	endfunction

endpackage

>>> hdl/kwdt_if.sv
// Valid/ready channel interfaces for commands and responses.
`timescale 1ns / 1ps
interface kwdt_cmd_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      mode;
	logic [kwdt_pkg::OFF_W-1:0]      reg_offset;
	logic [kwdt_pkg::DATA_W-1:0]     write_data;
	modport source (output valid, mode, reg_offset, write_data, input ready);
	modport sink (input valid, mode, reg_offset, write_data, output ready);
endinterface

interface kwdt_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [kwdt_pkg::DATA_W-1:0]     read_data;
	logic                            system_reset;
	logic                            expired;
	modport source (output valid, read_data, system_reset, expired, input ready);
	modport sink (input valid, read_data, system_reset, expired, output ready);
endinterface

>>> hdl/kwdt_engine.sv
// Watchdog state registers and the per-transfer update logic.
`timescale 1ns / 1ps
module kwdt_engine (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   go,
	input  kwdt_pkg::kwdt_item_t   item,
	input  kwdt_pkg::kwdt_cfg_t    cfg,
	output kwdt_pkg::kwdt_result_t result
);

	logic                                 enabled_q;
	logic [3:0]                           interval_q;
	logic [1:0]                           rst_fn_q;
	logic [kwdt_pkg::PRESCALE_WIDTH-1:0]  presc_q;
	logic [kwdt_pkg::HSC_W-1:0]           hsc_q;

	logic                                 enabled_d;
	logic [3:0]                           interval_d;
	logic [1:0]                           rst_fn_d;
	logic [kwdt_pkg::PRESCALE_WIDTH-1:0]  presc_d;
	logic [kwdt_pkg::HSC_W-1:0]           hsc_d;

	logic [kwdt_pkg::LIM_W-1:0]           limit;
	logic [kwdt_pkg::LIM_W-1:0]           cap;
	logic [kwdt_pkg::LIM_W-1:0]           next_cnt;
	logic [kwdt_pkg::HSC_W-1:0]           hsc_adv;
	logic                                 key_ok;
	logic                                 rst_sel;
	logic [kwdt_pkg::OFF_W-1:0]           ctrl_off;

	assign cap = kwdt_pkg::LIM_W'({1'b1, {kwdt_pkg::PRESCALE_WIDTH{1'b0}}});

	always_comb begin
		limit = (cfg.tphs == '0) ? kwdt_pkg::LIM_W'(1) : kwdt_pkg::LIM_W'(cfg.tphs);
		if (limit > cap) begin
			limit = cap;
		end
	end

	assign next_cnt = kwdt_pkg::LIM_W'(presc_q) + kwdt_pkg::LIM_W'(1);
	assign key_ok   = !cfg.key_check || (item.write_data[31:16] == kwdt_pkg::KEY_HALF);
	// layout 0 keeps only bit 1; layout 1 wants the field to equal one
	assign rst_sel  = cfg.layout ? (rst_fn_q == 2'b01) : rst_fn_q[1];
	assign ctrl_off = cfg.layout ? kwdt_pkg::OFF_CTRL1 : kwdt_pkg::OFF_CTRL0;

	always_comb begin
		enabled_d  = enabled_q;
		interval_d = interval_q;
		rst_fn_d   = rst_fn_q;
		presc_d    = presc_q;
		hsc_d      = hsc_q;
		hsc_adv    = hsc_q;
		result     = '0;
		case (kwdt_pkg::kwdt_mode_t'(item.mode))
			kwdt_pkg::MODE_WRITE: begin
				if (item.reg_offset == ctrl_off) begin
					if (item.write_data[12:0] == kwdt_pkg::RELOAD_PATTERN) begin
						presc_d = '0;
						hsc_d   = '0;
					end
				end else if (key_ok) begin
					if (!cfg.layout) begin
						if (item.reg_offset == kwdt_pkg::OFF_MODE0) begin
							enabled_d  = item.write_data[0];
							rst_fn_d   = {item.write_data[1], 1'b0};
							interval_d = item.write_data[6:3];
						end
					end else if (item.reg_offset == kwdt_pkg::OFF_CFG1) begin
						rst_fn_d = item.write_data[1:0];
					end else if (item.reg_offset == kwdt_pkg::OFF_MODE1) begin
						enabled_d  = item.write_data[0];
						interval_d = item.write_data[7:4];
					end
				end
			end
			kwdt_pkg::MODE_READ: begin
				if (!cfg.layout) begin
					if (item.reg_offset == kwdt_pkg::OFF_MODE0) begin
						result.read_data = {25'd0, interval_q, 1'b0, rst_fn_q[1], enabled_q};
					end
				end else if (item.reg_offset == kwdt_pkg::OFF_CFG1) begin
					result.read_data = {30'd0, rst_fn_q};
				end else if (item.reg_offset == kwdt_pkg::OFF_MODE1) begin
					result.read_data = {24'd0, interval_q, 3'd0, enabled_q};
				end
			end
			kwdt_pkg::MODE_TICK: begin
				if (!enabled_q) begin
					presc_d = '0;
					hsc_d   = '0;
				end else begin
					if (next_cnt >= limit) begin
						presc_d = '0;
						hsc_adv = hsc_q + kwdt_pkg::HSC_W'(1);
					end else begin
						presc_d = next_cnt[kwdt_pkg::PRESCALE_WIDTH-1:0];
					end
					hsc_d = hsc_adv;
					if (hsc_adv >= kwdt_pkg::half_seconds_of(interval_q)) begin
						result.expired      = 1'b1;
						result.system_reset = rst_sel;
						presc_d             = '0;
						hsc_d               = '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q  <= 1'b0;
			interval_q <= '0;
			rst_fn_q   <= '0;
			presc_q    <= '0;
			hsc_q      <= '0;
		end else if (go) begin
			enabled_q  <= enabled_d;
			interval_q <= interval_d;
			rst_fn_q   <= rst_fn_d;
			presc_q    <= presc_d;
			hsc_q      <= hsc_d;
		end
	end

endmodule

>>> hdl/keyed_watchdog_timer.sv
// Top level of the keyed watchdog timer: channels, config registers, pipeline.
`timescale 1ns / 1ps
`include "keyed_watchdog_timer_macros.svh"
// Usage:
//  cmd carries one bus write, bus read or clock tick per transfer (mode,
//  reg_offset, write_data). rsp returns exactly one result per command:
//  read_data for reads (zero otherwise), expired and system_reset for ticks.
//  Config writes (cfg_wr_en, cfg_index, cfg_data) set the register layout,
//  the key check and ticks per half second; do them only while idle.
//  Path: a command taken on cmd waits in the input register, then passes
//  through the engine into the result register, from which it transfers
//  on rsp (input register, then the result register).
//  Throughput: one command per cycle unless rsp is held off. The watchdog
//  state update is a single pass of logic between the input register and the
//  result register, so each command sees the state left by the one before it.
//  Stall: if rsp is held off, the result register and the input register
//  fill; cmd.ready drops only when both are full and rsp.ready is low.
//  Reset: arst_n clears the watchdog state (disabled, interval code zero,
//  counters zero), empties the pipeline and restores the config registers
//  to layout 0, key check off, 16384 ticks per half second.
module keyed_watchdog_timer (
	input  logic                           clk,
	input  logic                           arst_n,
	kwdt_cmd_if.sink                       cmd,
	kwdt_rsp_if.source                     rsp,
	input  logic                           cfg_wr_en,
	input  logic [kwdt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kwdt_pkg::CFG_DATA_W-1:0] cfg_data
);

	kwdt_pkg::kwdt_cfg_t    cfg_q;
	kwdt_pkg::kwdt_item_t   item_s1;
	logic                   item_vld_s1;
	kwdt_pkg::kwdt_result_t res_d;
	kwdt_pkg::kwdt_result_t res_q;
	logic                   rsp_vld_q;
	logic                   advance;
	logic                   cmd_xfer;

	// Config registers; writes to unused indexes fall through.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.layout    <= 1'b0;
			cfg_q.key_check <= 1'b0;
			cfg_q.tphs      <= kwdt_pkg::TPHS_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				kwdt_pkg::CFG_LAYOUT: cfg_q.layout    <= cfg_data[0];
				kwdt_pkg::CFG_KEY:    cfg_q.key_check <= cfg_data[0];
				kwdt_pkg::CFG_TPHS:   cfg_q.tphs      <= cfg_data[kwdt_pkg::TPHS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The held command moves on when the result register is free or draining.
	assign advance   = item_vld_s1 && (!rsp_vld_q || rsp.ready);
	assign cmd.ready = !item_vld_s1 || advance;
	assign cmd_xfer  = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			item_vld_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			item_s1.mode       <= cmd.mode;
			item_s1.reg_offset <= cmd.reg_offset;
			item_s1.write_data <= cmd.write_data;
		end
	end

	kwdt_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (res_d)
	);

	// Result register in front of rsp.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (advance) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign rsp.valid        = rsp_vld_q;
	assign rsp.read_data    = res_q.read_data;
	assign rsp.system_reset = res_q.system_reset;
	assign rsp.expired      = res_q.expired;

	// A reset request only ever comes with an expiry.
	`KWDT_ASSERT_NOW(a_rst_needs_expiry, rsp_vld_q && res_q.system_reset, res_q.expired)
	// Tick results never carry read data.
	`KWDT_ASSERT_NOW(a_expiry_no_data, rsp_vld_q && res_q.expired, res_q.read_data == '0)
	// A command that advances always lands in the result register.
	`KWDT_ASSERT_NEXT(a_advance_lands, advance, rsp_vld_q)
	// A held command is not dropped while the output is stalled.
	`KWDT_ASSERT_NEXT(a_hold_s1, item_vld_s1 && rsp_vld_q && !rsp.ready, item_vld_s1)

endmodule
